@@ src/sehc_pkg.sv @@
package sehc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int INDEX_BITS = 16;

  localparam int IDX_W  = 16;
  localparam int POS_W  = 32;
  localparam int LEN_W  = 32;
  localparam int MAG_W  = POS_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int ROOT_W = MAG_W;
  localparam int OUT_W  = 48;
  localparam int KD_W   = LEN_W + MAG_W;
  localparam int KL_W   = 2 * LEN_W;

  localparam int DIV_NUM_W = 98;
  localparam int DIV_DEN_W = SQ_W;
  localparam int DIV_Q_W   = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int NPAIR = 6;

  localparam int IDX_KEEP = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam logic [IDX_W:0] IDX_MASK_W = ((IDX_W + 1)'(1) << IDX_KEEP) - (IDX_W + 1)'(1);
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_MASK_W[IDX_W-1:0];

  localparam logic [OUT_W-1:0] NEG_LIM = OUT_W'(1) << (OUT_W - 1);
  localparam logic [OUT_W-1:0] POS_LIM = NEG_LIM - OUT_W'(1);
  localparam logic [OUT_W-1:0] E_MAX   = '1;

  // One spring as it leaves the front end
  typedef struct packed {
    logic [IDX_W-1:0]            a_idx;
    logic [IDX_W-1:0]            b_idx;
    logic [2:0]                  eneg;
    logic [2:0][MAG_W-1:0]       mag;
    logic [LEN_W-1:0]            rest;
    logic [LEN_W-1:0]            stiff;
    logic [ROOT_W-1:0]           len;
  } spring_t;

  // Side data carried along the divider stages of the back end
  typedef struct packed {
    logic [IDX_W-1:0]            a_idx;
    logic [IDX_W-1:0]            b_idx;
    logic [2:0]                  eneg;
    logic [2:0][MAG_W-1:0]       mag;
    logic                        dneg;
    logic                        zero;
    logic [SQ_W-1:0]             len2;
    logic [OUT_W-1:0]            energy;
    logic [OUT_W-1:0]            t1;
    logic [2:0][OUT_W-1:0]       grad;
  } bk_side_t;

  // Row and column of each unique Hessian entry: xx xy xz yy yz zz
  function automatic int pair_row(input int p);
    case (p)
      0, 1, 2: return 0;
      3, 4:    return 1;
      default: return 2;
    endcase
  endfunction

  function automatic int pair_col(input int p);
    case (p)
      0:       return 0;
      1, 3:    return 1;
      default: return 2;
    endcase
  endfunction

endpackage

@@ src/sehc_div.sv @@
module sehc_div
  import sehc_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_Q_W-1:0]   quo,
  output logic                 ovf
);

  logic [DIV_DEN_W-1:0] rem_r [DIV_Q_W];
  logic [DIV_Q_W-1:0]   low_r [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_r [DIV_Q_W];
  logic                 ovf_r [DIV_Q_W];

  // Restoring division, one quotient bit per stage
  for (genvar s = 0; s < DIV_Q_W; s++) begin : g_stage
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_Q_W-1:0]   low_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic                 ovf_in;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    if (s == 0) begin : g_head
      assign rem_in = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
      assign low_in = num[DIV_Q_W-1:0];
      assign den_in = den;
      assign ovf_in = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]) >= den;
    end else begin : g_body
      assign rem_in = rem_r[s-1];
      assign low_in = low_r[s-1];
      assign den_in = den_r[s-1];
      assign ovf_in = ovf_r[s-1];
    end

    assign shifted = {rem_in, low_in[DIV_Q_W-1]};
    assign ge      = shifted >= {1'b0, den_in};
    assign diff    = shifted - {1'b0, den_in};

    // Advance one bit
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
        low_r[s] <= {low_in[DIV_Q_W-2:0], ge};
        den_r[s] <= den_in;
        ovf_r[s] <= ovf_in;
      end
    end
  end

  assign quo = low_r[DIV_Q_W-1];
  assign ovf = ovf_r[DIV_Q_W-1];

endmodule

@@ src/sehc_front.sv @@
module sehc_front
  import sehc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [IDX_W-1:0]        in_node_a_index,
  input  logic [IDX_W-1:0]        in_node_b_index,
  input  logic signed [POS_W-1:0] in_ax,
  input  logic signed [POS_W-1:0] in_ay,
  input  logic signed [POS_W-1:0] in_az,
  input  logic signed [POS_W-1:0] in_bx,
  input  logic signed [POS_W-1:0] in_by_coord,
  input  logic signed [POS_W-1:0] in_bz,
  input  logic [LEN_W-1:0]        in_rest_len,
  input  logic [LEN_W-1:0]        in_stiff,
  output logic                    q_push,
  output spring_t                 q_wdata,
  input  logic                    q_full
);

  logic en_f;

  logic                  f1_v_r;
  spring_t               f1_sp_r, f1_sp_nxt;
  logic                  f2_v_r;
  spring_t               f2_sp_r;
  logic [2:0][SQ_W-1:0]  f2_sq_r;

  logic                  sv_r   [ROOT_W+1];
  spring_t               ssp_r  [ROOT_W+1];
  logic [SQ_W-1:0]       rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0]     root_r [ROOT_W+1];

  // Whole front advances unless the last stage is blocked by the queue
  assign en_f    = !(sv_r[ROOT_W] && q_full);
  assign in_full = !en_f;

  // Component differences and magnitudes
  always_comb begin
    logic [2:0][POS_W-1:0] pa;
    logic [2:0][POS_W-1:0] pb;
    logic [MAG_W-1:0]      e;
    pa = {in_az, in_ay, in_ax};
    pb = {in_bz, in_by_coord, in_bx};
    f1_sp_nxt       = '0;
    f1_sp_nxt.a_idx = in_node_a_index & IDX_MASK;
    f1_sp_nxt.b_idx = in_node_b_index & IDX_MASK;
    f1_sp_nxt.rest  = in_rest_len;
    f1_sp_nxt.stiff = in_stiff;
    for (int c = 0; c < 3; c++) begin
      e = {pa[c][POS_W-1], pa[c]} - {pb[c][POS_W-1], pb[c]};
      f1_sp_nxt.eneg[c] = e[MAG_W-1];
      f1_sp_nxt.mag[c]  = e[MAG_W-1] ? (~e + MAG_W'(1)) : e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      sv_r[0] <= 1'b0;
    end else if (en_f) begin
      f1_v_r  <= in_push;
      f2_v_r  <= f1_v_r;
      sv_r[0] <= f2_v_r;
    end
  end

  // Square, then sum the squares
  always_ff @(posedge clk) begin
    if (en_f) begin
      f1_sp_r <= f1_sp_nxt;
      f2_sp_r <= f1_sp_r;
      for (int c = 0; c < 3; c++) begin
        f2_sq_r[c] <= SQ_W'(f1_sp_r.mag[c]) * SQ_W'(f1_sp_r.mag[c]);
      end
      ssp_r[0]  <= f2_sp_r;
      rem_r[0]  <= f2_sq_r[0] + f2_sq_r[1] + f2_sq_r[2];
      root_r[0] <= '0;
    end
  end

  // Integer square root, one result bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int J = ROOT_W - 1 - k;
    logic [SQ_W+1:0] trial;
    logic            take;

    assign trial = ((SQ_W + 2)'(root_r[k]) << (J + 1)) + ((SQ_W + 2)'(1) << (2 * J));
    assign take  = {2'b0, rem_r[k]} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (en_f) begin
        sv_r[k+1] <= sv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en_f) begin
        ssp_r[k+1]  <= ssp_r[k];
        rem_r[k+1]  <= take ? (rem_r[k] - trial[SQ_W-1:0]) : rem_r[k];
        root_r[k+1] <= take ? (root_r[k] | (ROOT_W'(1) << J)) : root_r[k];
      end
    end
  end

  // Hand the classified spring to the queue
  always_comb begin
    q_wdata     = ssp_r[ROOT_W];
    q_wdata.len = root_r[ROOT_W];
  end
  assign q_push = sv_r[ROOT_W] && !q_full;

endmodule

@@ src/sehc_queue.sv @@
module sehc_queue
  import sehc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  spring_t wdata,
  output logic    full,
  input  logic    pop,
  output spring_t rdata,
  output logic    empty
);

  spring_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + (QPTR_W + 1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (QPTR_W + 1)'(1);
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

@@ src/sehc_back.sv @@
module sehc_back
  import sehc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  spring_t                 q_rdata,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [IDX_W-1:0]        out_a_index,
  output logic [IDX_W-1:0]        out_b_index,
  output logic [OUT_W-1:0]        out_energy,
  output logic signed [OUT_W-1:0] out_grad_x,
  output logic signed [OUT_W-1:0] out_grad_y,
  output logic signed [OUT_W-1:0] out_grad_z,
  output logic signed [OUT_W-1:0] out_hess_xx,
  output logic signed [OUT_W-1:0] out_hess_xy,
  output logic signed [OUT_W-1:0] out_hess_xz,
  output logic signed [OUT_W-1:0] out_hess_yy,
  output logic signed [OUT_W-1:0] out_hess_yz,
  output logic signed [OUT_W-1:0] out_hess_zz
);

  logic en_b;

  // Stage B1
  logic              b1_v_r;
  spring_t           b1_sp_r;
  logic [MAG_W-1:0]  b1_dmag_r, b1_dmag_nxt;
  logic              b1_dneg_r, b1_dneg_nxt;
  logic [KL_W-1:0]   b1_kl_r;
  // Stage B2
  logic              b2_v_r;
  spring_t           b2_sp_r;
  logic              b2_dneg_r;
  logic [KL_W-1:0]   b2_kl_r;
  logic [SQ_W-1:0]   b2_sq_r;
  logic [KD_W-1:0]   b2_kd_r;
  logic [SQ_W-1:0]   b2_len2_r;
  // Stage B3
  logic              b3_v_r;
  spring_t           b3_sp_r;
  logic              b3_dneg_r;
  logic [KD_W-1:0]   b3_kd_r;
  logic [SQ_W-1:0]   b3_len2_r;
  logic [KD_W-1:0]   b3_en_lo_r, b3_en_hi_r;
  logic [2:0][SQ_W-1:0]  b3_g_lo_r;
  logic [2:0][KD_W-1:0]  b3_g_hi_r;
  logic [2:0][KD_W-1:0]  b3_q_lo_r, b3_q_hi_r;
  // Stage B4
  logic              b4_v_r;
  spring_t           b4_sp_r;
  logic              b4_dneg_r;
  logic [KD_W-1:0]   b4_kd_r;
  logic [SQ_W-1:0]   b4_len2_r;
  logic [DIV_NUM_W-1:0]       b4_en_r;
  logic [2:0][DIV_NUM_W-1:0]  b4_gnum_r, b4_qnum_r;
  bk_side_t          b4_side;
  // First divider bank
  logic              dv1_r   [DIV_Q_W];
  bk_side_t          side1_r [DIV_Q_W];
  logic [DIV_Q_W-1:0]      t1_quo;
  logic                    t1_ovf;
  logic [2:0][DIV_Q_W-1:0] g_quo, q1_quo;
  logic [2:0]              g_ovf, q1_ovf;
  logic [DIV_DEN_W-1:0]    len_den, grad_den;
  // Stage B5
  logic              b5_v_r;
  bk_side_t          b5_side_r, b5_side_nxt;
  logic [NPAIR-1:0][KD_W-1:0] b5_plo_r, b5_phi_r;
  // Stage B6
  logic              b6_v_r;
  bk_side_t          b6_side_r;
  logic [NPAIR-1:0][DIV_NUM_W-1:0] b6_tnum_r;
  // Second divider bank
  logic              dv2_r   [DIV_Q_W];
  bk_side_t          side2_r [DIV_Q_W];
  logic [NPAIR-1:0][DIV_Q_W-1:0] t2_quo;
  logic [NPAIR-1:0]              t2_ovf;
  // Output stage
  logic              o_v_r;
  bk_side_t          o_side_r;
  logic [NPAIR-1:0][OUT_W-1:0] o_hess_r, o_hess_nxt;

  // Whole back end advances unless a result waits and is not taken
  assign en_b      = !o_v_r || out_pop;
  assign q_pop     = en_b;
  assign out_empty = !o_v_r;

  // Length error against rest length
  always_comb begin
    logic [ROOT_W+1:0] diff;
    diff        = {2'b0, q_rdata.len} - {3'b0, q_rdata.rest};
    b1_dneg_nxt = diff[ROOT_W+1];
    b1_dmag_nxt = b1_dneg_nxt ? MAG_W'(~diff + (ROOT_W + 2)'(1)) : MAG_W'(diff);
  end

  // Valid chain outside the divider banks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
      b5_v_r <= 1'b0;
      b6_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (en_b) begin
      b1_v_r <= !q_empty;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      b4_v_r <= b3_v_r;
      b5_v_r <= dv1_r[DIV_Q_W-1];
      b6_v_r <= b5_v_r;
      o_v_r  <= dv2_r[DIV_Q_W-1];
    end
  end

  // Products and partial products ahead of the first divider bank
  always_ff @(posedge clk) begin
    if (en_b) begin
      b1_sp_r   <= q_rdata;
      b1_dmag_r <= b1_dmag_nxt;
      b1_dneg_r <= b1_dneg_nxt;
      b1_kl_r   <= KL_W'(q_rdata.stiff) * KL_W'(q_rdata.rest);

      b2_sp_r   <= b1_sp_r;
      b2_dneg_r <= b1_dneg_r;
      b2_kl_r   <= b1_kl_r;
      b2_sq_r   <= SQ_W'(b1_dmag_r) * SQ_W'(b1_dmag_r);
      b2_kd_r   <= KD_W'(b1_sp_r.stiff) * KD_W'(b1_dmag_r);
      b2_len2_r <= SQ_W'(b1_sp_r.len) * SQ_W'(b1_sp_r.len);

      b3_sp_r    <= b2_sp_r;
      b3_dneg_r  <= b2_dneg_r;
      b3_kd_r    <= b2_kd_r;
      b3_len2_r  <= b2_len2_r;
      b3_en_lo_r <= KD_W'(b2_sq_r[MAG_W-1:0]) * KD_W'(b2_sp_r.stiff);
      b3_en_hi_r <= KD_W'(b2_sq_r[SQ_W-1:MAG_W]) * KD_W'(b2_sp_r.stiff);
      for (int c = 0; c < 3; c++) begin
        b3_g_lo_r[c] <= SQ_W'(b2_kd_r[MAG_W-1:0]) * SQ_W'(b2_sp_r.mag[c]);
        b3_g_hi_r[c] <= KD_W'(b2_kd_r[KD_W-1:MAG_W]) * KD_W'(b2_sp_r.mag[c]);
        b3_q_lo_r[c] <= KD_W'(b2_kl_r[LEN_W-1:0]) * KD_W'(b2_sp_r.mag[c]);
        b3_q_hi_r[c] <= KD_W'(b2_kl_r[KL_W-1:LEN_W]) * KD_W'(b2_sp_r.mag[c]);
      end

      b4_sp_r   <= b3_sp_r;
      b4_dneg_r <= b3_dneg_r;
      b4_kd_r   <= b3_kd_r;
      b4_len2_r <= b3_len2_r;
      b4_en_r   <= DIV_NUM_W'(b3_en_lo_r) + (DIV_NUM_W'(b3_en_hi_r) << MAG_W);
      for (int c = 0; c < 3; c++) begin
        b4_gnum_r[c] <= DIV_NUM_W'(b3_g_lo_r[c]) + (DIV_NUM_W'(b3_g_hi_r[c]) << MAG_W);
        b4_qnum_r[c] <= DIV_NUM_W'(b3_q_lo_r[c]) + (DIV_NUM_W'(b3_q_hi_r[c]) << LEN_W);
      end
    end
  end

  // Energy scaling and saturation, side data for the first divider bank
  always_comb begin
    b4_side        = '0;
    b4_side.a_idx  = b4_sp_r.a_idx;
    b4_side.b_idx  = b4_sp_r.b_idx;
    b4_side.eneg   = b4_sp_r.eneg;
    b4_side.mag    = b4_sp_r.mag;
    b4_side.dneg   = b4_dneg_r;
    b4_side.zero   = b4_sp_r.len == '0;
    b4_side.len2   = b4_len2_r;
    if (b4_en_r[DIV_NUM_W-1:FRAC_BITS+1+OUT_W] != '0) begin
      b4_side.energy = E_MAX;
    end else begin
      b4_side.energy = b4_en_r[FRAC_BITS+OUT_W:FRAC_BITS+1];
    end
  end

  assign len_den  = DIV_DEN_W'(b4_sp_r.len);
  assign grad_den = DIV_DEN_W'(b4_sp_r.len) << FRAC_BITS;

  sehc_div u_div_t1 (
    .clk (clk),
    .en  (en_b),
    .num (DIV_NUM_W'(b4_kd_r)),
    .den (len_den),
    .quo (t1_quo),
    .ovf (t1_ovf)
  );

  for (genvar c = 0; c < 3; c++) begin : g_div1
    sehc_div u_div_grad (
      .clk (clk),
      .en  (en_b),
      .num (b4_gnum_r[c]),
      .den (grad_den),
      .quo (g_quo[c]),
      .ovf (g_ovf[c])
    );
    sehc_div u_div_q1 (
      .clk (clk),
      .en  (en_b),
      .num (b4_qnum_r[c]),
      .den (len_den),
      .quo (q1_quo[c]),
      .ovf (q1_ovf[c])
    );
  end

  // Carry side data alongside the divider stages
  for (genvar s = 0; s < DIV_Q_W; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv1_r[s] <= 1'b0;
        dv2_r[s] <= 1'b0;
      end else if (en_b) begin
        dv1_r[s] <= (s == 0) ? b4_v_r : dv1_r[(s == 0) ? 0 : s - 1];
        dv2_r[s] <= (s == 0) ? b6_v_r : dv2_r[(s == 0) ? 0 : s - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en_b) begin
        side1_r[s] <= (s == 0) ? b4_side   : side1_r[(s == 0) ? 0 : s - 1];
        side2_r[s] <= (s == 0) ? b6_side_r : side2_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // Saturate the diagonal term and the gradient
  always_comb begin
    logic             gneg;
    logic [OUT_W-1:0] lim;
    logic [OUT_W-1:0] gmag;
    b5_side_nxt = side1_r[DIV_Q_W-1];
    if (t1_ovf || t1_quo > DIV_Q_W'(NEG_LIM)) b5_side_nxt.t1 = NEG_LIM;
    else b5_side_nxt.t1 = t1_quo[OUT_W-1:0];
    for (int c = 0; c < 3; c++) begin
      gneg = side1_r[DIV_Q_W-1].dneg ^ side1_r[DIV_Q_W-1].eneg[c];
      lim  = gneg ? NEG_LIM : POS_LIM;
      if (g_ovf[c] || g_quo[c] > DIV_Q_W'(lim)) gmag = lim;
      else gmag = g_quo[c][OUT_W-1:0];
      b5_side_nxt.grad[c] = gneg ? (~gmag + OUT_W'(1)) : gmag;
    end
  end

  // Outer-product numerators for the six unique entries
  always_ff @(posedge clk) begin
    if (en_b) begin
      b5_side_r <= b5_side_nxt;
      for (int p = 0; p < NPAIR; p++) begin
        b5_plo_r[p] <= KD_W'(q1_quo[pair_row(p)][LEN_W-1:0]) *
                       KD_W'(side1_r[DIV_Q_W-1].mag[pair_col(p)]);
        b5_phi_r[p] <= KD_W'(q1_quo[pair_row(p)][DIV_Q_W-1:LEN_W]) *
                       KD_W'(side1_r[DIV_Q_W-1].mag[pair_col(p)]);
      end
      b6_side_r <= b5_side_r;
      for (int p = 0; p < NPAIR; p++) begin
        b6_tnum_r[p] <= DIV_NUM_W'(b5_plo_r[p]) + (DIV_NUM_W'(b5_phi_r[p]) << LEN_W);
      end
    end
  end

  for (genvar p = 0; p < NPAIR; p++) begin : g_div2
    sehc_div u_div_t2 (
      .clk (clk),
      .en  (en_b),
      .num (b6_tnum_r[p]),
      .den (b6_side_r.len2),
      .quo (t2_quo[p]),
      .ovf (t2_ovf[p])
    );
  end

  // Combine outer part and diagonal term, then clamp
  always_comb begin
    bk_side_t                sd;
    logic [OUT_W-1:0]        t2;
    logic signed [OUT_W+1:0] acc;
    logic signed [OUT_W+1:0] dterm;
    sd    = side2_r[DIV_Q_W-1];
    dterm = sd.dneg ? -$signed({2'b0, sd.t1}) : $signed({2'b0, sd.t1});
    for (int p = 0; p < NPAIR; p++) begin
      if (t2_ovf[p] || t2_quo[p] > DIV_Q_W'(NEG_LIM)) t2 = NEG_LIM;
      else t2 = t2_quo[p][OUT_W-1:0];
      if (sd.eneg[pair_row(p)] ^ sd.eneg[pair_col(p)]) acc = -$signed({2'b0, t2});
      else acc = $signed({2'b0, t2});
      if (pair_row(p) == pair_col(p)) acc = acc + dterm;
      if (acc > $signed({2'b0, POS_LIM})) o_hess_nxt[p] = POS_LIM;
      else if (acc < -$signed({2'b0, NEG_LIM})) o_hess_nxt[p] = NEG_LIM;
      else o_hess_nxt[p] = acc[OUT_W-1:0];
      if (sd.zero) o_hess_nxt[p] = '0;
    end
  end

  // Hold the finished result for the consumer
  always_ff @(posedge clk) begin
    if (en_b) begin
      o_side_r <= side2_r[DIV_Q_W-1];
      o_hess_r <= o_hess_nxt;
    end
  end

  assign out_a_index = o_side_r.a_idx;
  assign out_b_index = o_side_r.b_idx;
  assign out_energy  = o_side_r.energy;
  assign out_grad_x  = o_side_r.zero ? '0 : o_side_r.grad[0];
  assign out_grad_y  = o_side_r.zero ? '0 : o_side_r.grad[1];
  assign out_grad_z  = o_side_r.zero ? '0 : o_side_r.grad[2];
  assign out_hess_xx = o_hess_r[0];
  assign out_hess_xy = o_hess_r[1];
  assign out_hess_xz = o_hess_r[2];
  assign out_hess_yy = o_hess_r[3];
  assign out_hess_yz = o_hess_r[4];
  assign out_hess_zz = o_hess_r[5];

endmodule

@@ src/spring_energy_gradient_hessian_core.sv @@
// Channel   Handshake        Beat contents
// input     in_push/in_full  node indices, endpoints a and b, rest length, stiffness
// result    out_pop/out_empty indices, energy, gradient on node a, six Hessian entries
//
// One spring is taken every cycle unless in_full stalls the input; the front end holds a
// 33-stage square root and the back end holds two 64-stage divider banks.
// Reset is synchronous and clears only valid bits, queue pointers and the queue fill count.
// The front stalls only when the four-entry queue is full; the back stalls only
// while a finished result is held and not popped.
module spring_energy_gradient_hessian_core
  import sehc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [IDX_W-1:0]        in_node_a_index,
  input  logic [IDX_W-1:0]        in_node_b_index,
  input  logic signed [POS_W-1:0] in_ax,
  input  logic signed [POS_W-1:0] in_ay,
  input  logic signed [POS_W-1:0] in_az,
  input  logic signed [POS_W-1:0] in_bx,
  input  logic signed [POS_W-1:0] in_by_coord,
  input  logic signed [POS_W-1:0] in_bz,
  input  logic [LEN_W-1:0]        in_rest_len,
  input  logic [LEN_W-1:0]        in_stiff,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [IDX_W-1:0]        out_a_index,
  output logic [IDX_W-1:0]        out_b_index,
  output logic [OUT_W-1:0]        out_energy,
  output logic signed [OUT_W-1:0] out_grad_x,
  output logic signed [OUT_W-1:0] out_grad_y,
  output logic signed [OUT_W-1:0] out_grad_z,
  output logic signed [OUT_W-1:0] out_hess_xx,
  output logic signed [OUT_W-1:0] out_hess_xy,
  output logic signed [OUT_W-1:0] out_hess_xz,
  output logic signed [OUT_W-1:0] out_hess_yy,
  output logic signed [OUT_W-1:0] out_hess_yz,
  output logic signed [OUT_W-1:0] out_hess_zz
);

  logic    q_push, q_full, q_pop, q_empty;
  spring_t q_wdata, q_rdata;

  // Length and classification
  sehc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_node_a_index (in_node_a_index),
    .in_node_b_index (in_node_b_index),
    .in_ax           (in_ax),
    .in_ay           (in_ay),
    .in_az           (in_az),
    .in_bx           (in_bx),
    .in_by_coord     (in_by_coord),
    .in_bz           (in_bz),
    .in_rest_len     (in_rest_len),
    .in_stiff        (in_stiff),
    .q_push          (q_push),
    .q_wdata         (q_wdata),
    .q_full          (q_full)
  );

  // Decouple front and back
  sehc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Energy, gradient and Hessian
  sehc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_rdata     (q_rdata),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_a_index (out_a_index),
    .out_b_index (out_b_index),
    .out_energy  (out_energy),
    .out_grad_x  (out_grad_x),
    .out_grad_y  (out_grad_y),
    .out_grad_z  (out_grad_z),
    .out_hess_xx (out_hess_xx),
    .out_hess_xy (out_hess_xy),
    .out_hess_xz (out_hess_xz),
    .out_hess_yy (out_hess_yy),
    .out_hess_yz (out_hess_yz),
    .out_hess_zz (out_hess_zz)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import sehc_pkg::*;

  // One spring beat and the result it should produce
  typedef struct {
    logic [IDX_W-1:0] a_idx, b_idx;
    logic signed [POS_W-1:0] ax, ay, az, bx, by, bz;
    logic [LEN_W-1:0] rest, stiff;
  } spring_beat_t;

  typedef struct {
    logic [IDX_W-1:0] a_idx, b_idx;
    logic [OUT_W-1:0] energy;
    logic [OUT_W-1:0] grad [3];
    logic [OUT_W-1:0] hess [6];
  } spring_terms_t;

  // Clamp a magnitude, then apply a sign and fold to 48 bits
  function automatic logic [OUT_W-1:0] signed_clamp(input bit neg, input logic [255:0] m);
    logic [255:0] lim;
    logic [255:0] v;
    lim = neg ? 256'(NEG_LIM) : 256'(POS_LIM);
    v = (m > lim) ? lim : m;
    return neg ? OUT_W'(-v) : OUT_W'(v);
  endfunction

  function automatic spring_terms_t spring_terms(input spring_beat_t s);
    spring_terms_t r;
    logic signed [33:0] e [3];
    logic [255:0] m [3], sq, len, cand, lrest, k, dmag, en, kd, len2, t1, q1, t2;
    logic signed [255:0] v;
    bit dneg;
    int p, ra, cb;
    e[0] = 34'(s.ax) - 34'(s.bx);
    e[1] = 34'(s.ay) - 34'(s.by);
    e[2] = 34'(s.az) - 34'(s.bz);
    lrest = 256'(s.rest);
    k = 256'(s.stiff);
    sq = '0;
    for (int c = 0; c < 3; c++) begin
      m[c] = e[c] < 0 ? 256'(-e[c]) : 256'(e[c]);
      sq += m[c] * m[c];
    end
    len = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = len | (256'(1) << b);
      if (cand * cand <= sq) len = cand;
    end
    dneg = len < lrest;
    dmag = dneg ? lrest - len : len - lrest;
    r.a_idx = s.a_idx & IDX_MASK;
    r.b_idx = s.b_idx & IDX_MASK;
    en = (dmag * dmag * k) >> (FRAC_BITS + 1);
    r.energy = en > 256'(E_MAX) ? E_MAX : en[OUT_W-1:0];
    for (int c = 0; c < 3; c++) r.grad[c] = '0;
    for (int c = 0; c < 6; c++) r.hess[c] = '0;
    if (len == 0) return r;
    kd = k * dmag;
    len2 = len * len;
    t1 = kd / len;
    if (t1 > 256'(NEG_LIM)) t1 = 256'(NEG_LIM);
    for (int c = 0; c < 3; c++)
      r.grad[c] = signed_clamp(dneg != (e[c] < 0), (kd * m[c]) / (len << FRAC_BITS));
    p = 0;
    for (ra = 0; ra < 3; ra++) begin
      // k*L is taken modulo 2^64 as the datapath keeps it
      q1 = (256'(64'(k * lrest)) * m[ra]) / len;
      for (cb = ra; cb < 3; cb++) begin
        t2 = (q1 * m[cb]) / len2;
        if (t2 > 256'(NEG_LIM)) t2 = 256'(NEG_LIM);
        v = ((e[ra] < 0) != (e[cb] < 0)) ? -$signed(t2) : $signed(t2);
        if (ra == cb) v = dneg ? v - $signed(t1) : v + $signed(t1);
        if (v > $signed(256'(POS_LIM))) v = $signed(256'(POS_LIM));
        if (v < -$signed(256'(NEG_LIM))) v = -$signed(256'(NEG_LIM));
        r.hess[p] = v[OUT_W-1:0];
        p++;
      end
    end
    return r;
  endfunction

  // Hold expected spring terms in arrival order and compare results
  class spring_scoreboard;
    spring_terms_t pending_terms[$];
    int errors;

    function void note_spring(input spring_beat_t s);
      pending_terms.insert(pending_terms.size(), spring_terms(s));
    endfunction

    function void check_field(input string nm, input logic [OUT_W-1:0] exp_v,
                              input logic [OUT_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, nm, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_terms(input spring_terms_t got);
      spring_terms_t w;
      string hn [6];
      hn = '{"hess_xx", "hess_xy", "hess_xz", "hess_yy", "hess_yz", "hess_zz"};
      if (pending_terms.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual a_idx %h", $time,
                 got.a_idx);
        errors++;
        return;
      end
      w = pending_terms.pop_front();
      check_field("a_index", OUT_W'(w.a_idx), OUT_W'(got.a_idx));
      check_field("b_index", OUT_W'(w.b_idx), OUT_W'(got.b_idx));
      check_field("energy", w.energy, got.energy);
      check_field("grad_x", w.grad[0], got.grad[0]);
      check_field("grad_y", w.grad[1], got.grad[1]);
      check_field("grad_z", w.grad[2], got.grad[2]);
      for (int i = 0; i < 6; i++) check_field(hn[i], w.hess[i], got.hess[i]);
    endfunction
  endclass

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_push = 1'b0, out_pop = 1'b0;
  logic in_full, out_empty;
  logic [IDX_W-1:0] in_node_a_index = '0, in_node_b_index = '0;
  logic signed [POS_W-1:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic signed [POS_W-1:0] in_bx = '0, in_by_coord = '0, in_bz = '0;
  logic [LEN_W-1:0] in_rest_len = '0, in_stiff = '0;
  logic [IDX_W-1:0] out_a_index, out_b_index;
  logic [OUT_W-1:0] out_energy;
  logic signed [OUT_W-1:0] out_grad_x, out_grad_y, out_grad_z;
  logic signed [OUT_W-1:0] out_hess_xx, out_hess_xy, out_hess_xz;
  logic signed [OUT_W-1:0] out_hess_yy, out_hess_yz, out_hess_zz;

  spring_energy_gradient_hessian_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spring_scoreboard sb = new();
  bit calm_phase = 0;
  bit hold_results = 0;
  int unsigned cycle_count = 0;

  // Note accepted beats and check popped ones at each edge
  always @(posedge clk) begin
    spring_beat_t s;
    spring_terms_t got;
    if (rst_n && in_push && !in_full) begin
      s.a_idx = in_node_a_index; s.b_idx = in_node_b_index;
      s.ax = in_ax; s.ay = in_ay; s.az = in_az;
      s.bx = in_bx; s.by = in_by_coord; s.bz = in_bz;
      s.rest = in_rest_len; s.stiff = in_stiff;
      sb.note_spring(s);
    end
    if (rst_n && out_pop && !out_empty) begin
      got.a_idx = out_a_index; got.b_idx = out_b_index; got.energy = out_energy;
      got.grad = '{out_grad_x, out_grad_y, out_grad_z};
      got.hess = '{out_hess_xx, out_hess_xy, out_hess_xz, out_hess_yy, out_hess_yz,
                   out_hess_zz};
      sb.check_terms(got);
    end
  end

  // Drain side: random stall bursts, plus a long hold-off when asked
  always @(posedge clk) begin
    int stall;
    if (!rst_n || hold_results) begin
      out_pop <= 1'b0;
    end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
      out_pop <= 1'b0;
      stall = $urandom_range(1, 13);
      repeat (stall - 1) @(posedge clk);
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 32'h0003_FFFF);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 32'h0003_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_spring(input spring_beat_t s);
    int gap;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      // Drop the offer while idling so the previous beat is not taken again
      in_push <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_node_a_index <= s.a_idx; in_node_b_index <= s.b_idx;
    in_ax <= s.ax; in_ay <= s.ay; in_az <= s.az;
    in_bx <= s.bx; in_by_coord <= s.by; in_bz <= s.bz;
    in_rest_len <= s.rest; in_stiff <= s.stiff;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic push_idle();
    in_push <= 1'b0;
  endtask

  function automatic spring_beat_t rand_spring();
    spring_beat_t s;
    s.a_idx = IDX_W'($urandom); s.b_idx = IDX_W'($urandom);
    s.ax = pick_word(); s.ay = pick_word(); s.az = pick_word();
    // Mostly short springs near a realistic scale, some wide ones
    if ($urandom_range(0, 2) != 0) begin
      s.bx = s.ax + $signed(32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000);
      s.by = s.ay + $signed(32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000);
      s.bz = s.az + $signed(32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000);
    end else begin
      s.bx = pick_word(); s.by = pick_word(); s.bz = pick_word();
    end
    s.rest = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 32'h000C_0000) : pick_word();
    s.stiff = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 32'h00FF_FFFF) : pick_word();
    return s;
  endfunction

  function automatic spring_beat_t mk(input logic [31:0] ax, ay, az, bx, by, bz,
                                      input logic [31:0] rest, stiff);
    spring_beat_t s;
    s.a_idx = IDX_W'($urandom); s.b_idx = IDX_W'($urandom);
    s.ax = ax; s.ay = ay; s.az = az; s.bx = bx; s.by = by; s.bz = bz;
    s.rest = rest; s.stiff = stiff;
    return s;
  endfunction

  initial begin
    spring_beat_t s;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero length, axis springs, extreme coordinates and saturation
    push_spring(mk(0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000));
    push_spring(mk(32'h1234_0000, 5, 7, 32'h1234_0000, 5, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_spring(mk(32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000));
    push_spring(mk(32'h0002_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000));
    push_spring(mk(0, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 32'h0008_0000, 32'h000A_0000));
    push_spring(mk(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000));
    push_spring(mk(1, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    push_spring(mk(1, 1, 1, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_spring(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 0, 32'hFFFF_FFFF));
    push_spring(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_spring(mk(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'h0001_0000, 0));
    push_spring(mk(32'hFFFF_0000, 32'h0001_0000, 0, 32'h0001_0000, 32'hFFFF_0000, 0,
                   32'h0001_0000, 32'h0010_0000));
    s = mk(0, 0, 0, 32'h0000_8000, 0, 32'hFFFF_8000, 32'h0010_0000, 32'h0100_0000);
    s.a_idx = 16'hFFFF; s.b_idx = 16'h0000;
    push_spring(s);
    s = mk(0, 0, 0, 0, 0, 0, 0, 0);
    s.a_idx = 16'h0000; s.b_idx = 16'hFFFF;
    push_spring(s);

    // Receiver holds off long enough for the block to back up into the input
    hold_results = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_results = 0;
      end
      for (int i = 0; i < 250; i++) push_spring(rand_spring());
    join
    push_idle();

    // Sender pauses until every expected result is out
    while (sb.pending_terms.size() != 0) @(posedge clk);

    for (int i = 0; i < 300; i++) push_spring(rand_spring());
    calm_phase = 1;
    for (int i = 0; i < 100; i++) push_spring(rand_spring());
    push_idle();

    while (sb.pending_terms.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
